### rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Three-card sum query package
// Shared widths, command codes and the token that moves along the cell row.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int CARD_W        = 20;
  localparam int TARGET_W      = 22;
  localparam int FUNC_W        = 2;
  localparam int MAX_CARDS_DEF = 1024;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic              v;
    logic              hit;
    logic [CARD_W-1:0] need;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

### rtl/tcs_ram.sv
// ----------------------------------------------------------------------------
// Card memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module tcs_ram import tcs_pkg::*; #(
  parameter int DEPTH = MAX_CARDS_DEF,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CARD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [CARD_W-1:0] rdata_a,
  output logic [CARD_W-1:0] rdata_b
);

  logic [CARD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/tcs_cell.sv
// ----------------------------------------------------------------------------
// Card cell
// Holds one card and checks the passing token against it.
// ----------------------------------------------------------------------------
module tcs_cell import tcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              shift_en,
  input  logic [CARD_W-1:0] card_in,
  output logic [CARD_W-1:0] card_out,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [CARD_W-1:0] card_r;
  logic              v_r;
  logic              hit_r;
  logic [CARD_W-1:0] need_r;
  logic              hit_nxt;

  assign hit_nxt = tok_in.hit | (tok_in.v & en & (card_r == tok_in.need));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v_r   <= tok_in.v;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r <= tok_in.need;
    if (shift_en) begin
      card_r <= card_in;
    end
  end

  assign card_out     = card_r;
  assign tok_out.v    = v_r;
  assign tok_out.hit  = hit_r;
  assign tok_out.need = need_r;

endmodule

### rtl/tcs_chain.sv
// ----------------------------------------------------------------------------
// Card cell row
// A row of card cells; loads shift in at the head, tokens flow to the tail.
// ----------------------------------------------------------------------------
module tcs_chain import tcs_pkg::*; #(
  parameter int N  = MAX_CARDS_DEF,
  parameter int CW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CW-1:0]     count,
  input  logic              shift_en,
  input  logic [CARD_W-1:0] card_in,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [CARD_W-1:0] card_w [N+1];
  tok_t              tok_w  [N+1];

  assign card_w[0] = card_in;
  assign tok_w[0]  = tok_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tcs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (CW'(i) < count),
      .shift_en (shift_en),
      .card_in  (card_w[i]),
      .card_out (card_w[i+1]),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1])
    );
  end

  assign tok_out = tok_w[N];

endmodule

### rtl/three_card_sum_query.sv
// ----------------------------------------------------------------------------
// Three-card sum query
// Keeps a store of cards and answers whether three of them, repeats allowed,
// sum to a target with the third card at least one.
//
// Channel   Direction  Handshake            Payload
// in        input      start & !busy        in_func, in_card_value, in_target_value
// out       output     out_valid strobe     out_target_echo, out_possible
//
// Clear and load beats leave busy low.
// A query on n stored cards issues one card pair per cycle from the card
// memory, and each pair's remainder then runs down a row of MAX_CARDS cells.
// Synchronous reset empties the store; there is no clearing pass.
// The receiver cannot stall: out_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
module three_card_sum_query import tcs_pkg::*; #(
  parameter int MAX_CARDS = MAX_CARDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CARD_W-1:0]   in_card_value,
  input  logic [TARGET_W-1:0] in_target_value,
  output logic                out_valid,
  output logic [TARGET_W-1:0] out_target_echo,
  output logic                out_possible
);

  localparam int AW        = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int CW        = AW + 1;
  localparam int DRAIN_LEN = MAX_CARDS + 4;
  localparam int DW        = $clog2(DRAIN_LEN + 1);
  localparam int DIFF_W    = TARGET_W + 1;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [DW-1:0]       drain_r, drain_nxt;
  logic                iss_v_r;
  tok_t                tok_r, tok_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_possible_r, out_possible_nxt;
  logic [TARGET_W-1:0] out_target_r, out_target_nxt;

  logic                accept;
  logic                load_we;
  logic                last_j;
  logic [CARD_W-1:0]   card_a, card_b;
  logic [DIFF_W-1:0]   diff;
  logic                need_ok;
  tok_t                chain_out;

  assign accept  = start & ~busy;
  assign busy    = (state_r != ST_IDLE);
  assign load_we = accept & (in_func == FUNC_LOAD) & (count_r < CW'(MAX_CARDS));
  assign last_j  = (({1'b0, j_r} + CW'(1)) == count_r);

  assign diff    = {1'b0, target_r} - {{(DIFF_W-CARD_W){1'b0}}, card_a}
                                    - {{(DIFF_W-CARD_W){1'b0}}, card_b};
  assign need_ok = ~diff[DIFF_W-1] & (diff != '0) & (diff[DIFF_W-2:CARD_W] == '0);

  tcs_ram #(
    .DEPTH (MAX_CARDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (load_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_card_value),
    .raddr_a (j_r),
    .raddr_b (k_r),
    .rdata_a (card_a),
    .rdata_b (card_b)
  );

  tcs_chain #(
    .N  (MAX_CARDS),
    .CW (CW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .count    (count_r),
    .shift_en (load_we),
    .card_in  (in_card_value),
    .tok_in   (tok_r),
    .tok_out  (chain_out)
  );

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    j_nxt            = j_r;
    k_nxt            = k_r;
    target_nxt       = target_r;
    drain_nxt        = drain_r;
    hit_nxt          = hit_r | (chain_out.v & chain_out.hit);
    out_valid_nxt    = 1'b0;
    out_possible_nxt = out_possible_r;
    out_target_nxt   = out_target_r;
    tok_nxt.v        = iss_v_r & need_ok;
    tok_nxt.hit      = 1'b0;
    tok_nxt.need     = diff[CARD_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            FUNC_LOAD: begin
              if (load_we) begin
                count_nxt = count_r + CW'(1);
              end
            end
            FUNC_QUERY: begin
              target_nxt = in_target_value;
              j_nxt      = '0;
              k_nxt      = '0;
              hit_nxt    = 1'b0;
              if (count_r == '0) begin
                state_nxt = ST_DRAIN;
                drain_nxt = DW'(DRAIN_LEN);
              end else begin
                state_nxt = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (k_r == j_r) begin
          if (last_j) begin
            state_nxt = ST_DRAIN;
            drain_nxt = DW'(DRAIN_LEN);
          end else begin
            j_nxt = j_r + AW'(1);
            k_nxt = '0;
          end
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt        = ST_IDLE;
          out_valid_nxt    = 1'b1;
          out_possible_nxt = hit_r;
          out_target_nxt   = target_r;
        end else begin
          drain_nxt = drain_r - DW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      iss_v_r     <= 1'b0;
      tok_r.v     <= 1'b0;
      tok_r.hit   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      drain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_v_r     <= (state_r == ST_RUN);
      tok_r       <= tok_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r            <= j_nxt;
    k_r            <= k_nxt;
    target_r       <= target_nxt;
    out_possible_r <= out_possible_nxt;
    out_target_r   <= out_target_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_possible    = out_possible_r;
  assign out_target_echo = out_target_r;

  // The result beat always follows the drain phase.
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DRAIN))
    else $error("result beat without a finished drain phase");

  // The card count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CARDS))
    else $error("card count beyond store depth");

  // No remainder token is in flight at the head of the row while idle.
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !tok_r.v && !iss_v_r)
    else $error("token issued while idle");

  // Loads never change the store during a query.
  a_store_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> $stable(count_r))
    else $error("card count changed during a query");

endmodule
